FILE: rtl/core/section_arc_radius_estimator_core_assert.svh
// assertion macros used by the section arc radius estimator controller
`ifndef SECTION_ARC_RADIUS_ESTIMATOR_CORE_ASSERT_SVH
`define SECTION_ARC_RADIUS_ESTIMATOR_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define SAREC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sarec assertion failed");

// next-cycle implication, disabled while reset is high
`define SAREC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sarec assertion failed");

`endif

FILE: rtl/core/sarec_pkg.sv
// shared widths, constants, state, command and status types of the arc radius estimator
`default_nettype none

package sarec_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int XY_W      = 27;
  localparam int IN_ANG_W  = 25;
  localparam int ANG_W     = 24;
  localparam int SEC_W     = 8;
  localparam int TDATA_W   = 80;
  localparam int SUM_W     = 40;
  localparam int DIFF_W    = XY_W + 1;
  localparam int ROOT_W    = DIFF_W;
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int RREM_W    = ROOT_W + 2;
  localparam int QUO_W     = SUM_W;
  localparam int BASE_W    = SUM_W + 8;
  localparam int PI_BITS   = 29;
  localparam int PI_W      = 31;
  localparam int MUL_SPLIT = 32;
  localparam int PLO_W     = MUL_SPLIT + PI_W;
  localparam int PHI_W     = (SUM_W - MUL_SPLIT) + PI_W;
  localparam int DEN_W     = SUM_W + PI_W;
  localparam int REM_W     = DEN_W + 1;
  localparam int CNT_W     = $clog2(QUO_W);

  localparam logic [PI_W-1:0]   PI_FIXED      = 31'd1686629713;
  localparam logic [BASE_W-1:0] DEG_HALF_TURN = 48'd180;
  localparam logic [SUM_W-1:0]  SUM_MAX       = {SUM_W{1'b1}};
  localparam logic [ANG_W-1:0]  ANG_MAX       = {ANG_W{1'b1}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SUMSQ,
    ST_ROOT,
    ST_ACCUM,
    ST_CHECK,
    ST_DEN,
    ST_DIV_LOAD,
    ST_DIV_CHECK,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic square;
    logic root_load;
    logic root_step;
    logic accum;
    logic check;
    logic den;
    logic div_load;
    logic div_check;
    logic div_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic seg_en;
    logic last;
    logic angle_zero;
    logic div_over;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/core/sarec_ctrl.sv
// controller state machine: sequences square root, accumulation and division
`default_nettype none

module sarec_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  s_tvalid,
  output logic                 s_tready,
  input  sarec_pkg::status_t   status,
  output sarec_pkg::cmd_t      cmd
);

  `include "section_arc_radius_estimator_core_assert.svh"

  sarec_pkg::state_t            state, state_next;
  logic [sarec_pkg::CNT_W-1:0]  cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sarec_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // next state and step counter
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      sarec_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = sarec_pkg::ST_SQUARE;
      end
      sarec_pkg::ST_SQUARE: begin
        if (status.seg_en)    state_next = sarec_pkg::ST_SUMSQ;
        else if (status.last) state_next = sarec_pkg::ST_CHECK;
        else                  state_next = sarec_pkg::ST_IDLE;
      end
      sarec_pkg::ST_SUMSQ: begin
        state_next = sarec_pkg::ST_ROOT;
        cnt_next   = sarec_pkg::CNT_W'(sarec_pkg::ROOT_W - 1);
      end
      sarec_pkg::ST_ROOT: begin
        if (cnt == '0) state_next = sarec_pkg::ST_ACCUM;
        else           cnt_next   = cnt - 1'b1;
      end
      sarec_pkg::ST_ACCUM: begin
        state_next = status.last ? sarec_pkg::ST_CHECK : sarec_pkg::ST_IDLE;
      end
      sarec_pkg::ST_CHECK: begin
        state_next = status.angle_zero ? sarec_pkg::ST_EMIT : sarec_pkg::ST_DEN;
      end
      sarec_pkg::ST_DEN: begin
        state_next = sarec_pkg::ST_DIV_LOAD;
      end
      sarec_pkg::ST_DIV_LOAD: begin
        state_next = sarec_pkg::ST_DIV_CHECK;
      end
      sarec_pkg::ST_DIV_CHECK: begin
        if (status.div_over) begin
          state_next = sarec_pkg::ST_EMIT;
        end else begin
          state_next = sarec_pkg::ST_DIVIDE;
          cnt_next   = sarec_pkg::CNT_W'(sarec_pkg::QUO_W - 1);
        end
      end
      sarec_pkg::ST_DIVIDE: begin
        if (cnt == '0) state_next = sarec_pkg::ST_EMIT;
        else           cnt_next   = cnt - 1'b1;
      end
      sarec_pkg::ST_EMIT: begin
        if (status.out_free) state_next = sarec_pkg::ST_IDLE;
      end
      default: begin
        state_next = sarec_pkg::ST_IDLE;
      end
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      sarec_pkg::ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
      end
      sarec_pkg::ST_SQUARE:    cmd.square    = 1'b1;
      sarec_pkg::ST_SUMSQ:     cmd.root_load = 1'b1;
      sarec_pkg::ST_ROOT:      cmd.root_step = 1'b1;
      sarec_pkg::ST_ACCUM:     cmd.accum     = 1'b1;
      sarec_pkg::ST_CHECK:     cmd.check     = 1'b1;
      sarec_pkg::ST_DEN:       cmd.den       = 1'b1;
      sarec_pkg::ST_DIV_LOAD:  cmd.div_load  = 1'b1;
      sarec_pkg::ST_DIV_CHECK: cmd.div_check = 1'b1;
      sarec_pkg::ST_DIVIDE:    cmd.div_step  = 1'b1;
      sarec_pkg::ST_EMIT:      cmd.emit      = status.out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

  `SAREC_ASSERT_NXT(a_accept_to_square, clk, rst, s_tvalid && s_tready, state == sarec_pkg::ST_SQUARE)
  `SAREC_ASSERT_NXT(a_root_done, clk, rst, state == sarec_pkg::ST_ROOT && cnt == '0, state == sarec_pkg::ST_ACCUM)
  `SAREC_ASSERT_NXT(a_emit_to_idle, clk, rst, state == sarec_pkg::ST_EMIT && status.out_free, state == sarec_pkg::ST_IDLE)

endmodule

`default_nettype wire

FILE: rtl/core/sarec_dpath.sv
// datapath: previous point, squares, iterative root, sums, divider, output register
`default_nettype none

module sarec_dpath #(
  parameter int FRAC_BITS = sarec_pkg::FRAC_BITS_DEF
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_wen,
  input  wire  [sarec_pkg::SEC_W-1:0]       cfg_wdata,
  input  wire  [sarec_pkg::TDATA_W-1:0]     s_tdata,
  input  wire  [sarec_pkg::SEC_W-1:0]       s_tuser,
  input  wire                               s_tlast,
  output logic                              m_tvalid,
  input  wire                               m_tready,
  output logic [sarec_pkg::TDATA_W-1:0]     m_tdata,
  output logic [0:0]                        m_tuser,
  input  sarec_pkg::cmd_t                   cmd,
  output sarec_pkg::status_t                status
);

  localparam int SHIFT = FRAC_BITS + sarec_pkg::PI_BITS;
  localparam int NUM_W = sarec_pkg::BASE_W + SHIFT;
  localparam int HI_W  = NUM_W - sarec_pkg::QUO_W;

  // input unpacking
  logic signed [sarec_pkg::XY_W-1:0]     in_x, in_y;
  logic signed [sarec_pkg::IN_ANG_W-1:0] in_ang;
  logic [sarec_pkg::IN_ANG_W-1:0]        ang_mag;
  logic [sarec_pkg::ANG_W-1:0]           abs_ang;

  assign in_x   = s_tdata[sarec_pkg::XY_W-1:0];
  assign in_y   = s_tdata[2*sarec_pkg::XY_W-1:sarec_pkg::XY_W];
  assign in_ang = s_tdata[2*sarec_pkg::XY_W+sarec_pkg::IN_ANG_W-1:2*sarec_pkg::XY_W];
  assign ang_mag = in_ang[sarec_pkg::IN_ANG_W-1] ? (~in_ang + 1'b1) : in_ang;
  // the most negative heading saturates
  assign abs_ang = ang_mag[sarec_pkg::IN_ANG_W-1] ? sarec_pkg::ANG_MAX
                                                  : ang_mag[sarec_pkg::ANG_W-1:0];

  // state and working registers
  logic [sarec_pkg::SEC_W-1:0]          target;
  logic signed [sarec_pkg::XY_W-1:0]    prev_x, prev_y;
  logic [sarec_pkg::ANG_W-1:0]          prev_angle;
  logic [sarec_pkg::SEC_W-1:0]          prev_section;
  logic                                 prev_valid;
  logic [sarec_pkg::SUM_W-1:0]          distance_sum, angle_sum;

  logic signed [sarec_pkg::DIFF_W-1:0]  dx, dy;
  logic [sarec_pkg::ANG_W-1:0]          ang_add;
  logic                                 seg_en, last;
  logic [sarec_pkg::RAD_W-1:0]          sq_x, sq_y, rad;
  logic [sarec_pkg::RREM_W-1:0]         rrem;
  logic [sarec_pkg::ROOT_W-1:0]         root;
  logic [sarec_pkg::BASE_W-1:0]         base;
  logic [sarec_pkg::PLO_W-1:0]          p_lo;
  logic [sarec_pkg::PHI_W-1:0]          p_hi;
  logic [sarec_pkg::DEN_W-1:0]          den;
  logic [sarec_pkg::REM_W-1:0]          drem;
  logic [sarec_pkg::QUO_W-1:0]          num_lo, quo;
  logic                                 sat;
  logic [sarec_pkg::SUM_W-1:0]          out_dist, out_rad;
  logic                                 out_zero;

  // combinational helpers
  logic signed [sarec_pkg::DIFF_W-1:0]  dx_next, dy_next;
  logic signed [sarec_pkg::RAD_W-1:0]   sqx_full, sqy_full;
  logic [sarec_pkg::RREM_W-1:0]         rrem_sh, rtrial;
  logic [sarec_pkg::SUM_W:0]            dsum_add, asum_add;
  logic [NUM_W-1:0]                     num_full;
  logic [sarec_pkg::REM_W-1:0]          drem_sh, den_ext;
  logic                                 seg_next;

  assign dx_next  = sarec_pkg::DIFF_W'(in_x) - sarec_pkg::DIFF_W'(prev_x);
  assign dy_next  = sarec_pkg::DIFF_W'(in_y) - sarec_pkg::DIFF_W'(prev_y);
  assign seg_next = prev_valid && (prev_section == target) && (s_tuser == target);

  assign sqx_full = dx * dx;
  assign sqy_full = dy * dy;

  // one result bit per root step
  assign rrem_sh = {rrem[sarec_pkg::RREM_W-3:0], rad[sarec_pkg::RAD_W-1:sarec_pkg::RAD_W-2]};
  assign rtrial  = {root, 2'b01};

  assign dsum_add = {1'b0, distance_sum} + {{(sarec_pkg::SUM_W-sarec_pkg::ROOT_W+1){1'b0}}, root};
  assign asum_add = {1'b0, angle_sum} + {{(sarec_pkg::SUM_W-sarec_pkg::ANG_W+1){1'b0}}, ang_add};

  assign num_full = {base, {SHIFT{1'b0}}};
  assign den_ext  = {1'b0, den};
  assign drem_sh  = {drem[sarec_pkg::REM_W-2:0], num_lo[sarec_pkg::QUO_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      target       <= '0;
      prev_valid   <= 1'b0;
      distance_sum <= '0;
      angle_sum    <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_wen) target <= cfg_wdata;

      if (cmd.accept) prev_valid <= 1'b1;
      else if (cmd.emit) prev_valid <= 1'b0;

      if (cmd.accum && seg_en) begin
        distance_sum <= dsum_add[sarec_pkg::SUM_W] ? sarec_pkg::SUM_MAX
                                                   : dsum_add[sarec_pkg::SUM_W-1:0];
        angle_sum    <= asum_add[sarec_pkg::SUM_W] ? sarec_pkg::SUM_MAX
                                                   : asum_add[sarec_pkg::SUM_W-1:0];
      end else if (cmd.emit) begin
        distance_sum <= '0;
        angle_sum    <= '0;
      end

      if (cmd.emit) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      dx           <= dx_next;
      dy           <= dy_next;
      seg_en       <= seg_next;
      last         <= s_tlast;
      ang_add      <= prev_angle;
      prev_x       <= in_x;
      prev_y       <= in_y;
      prev_angle   <= abs_ang;
      prev_section <= s_tuser;
    end

    if (cmd.square) begin
      sq_x <= $unsigned(sqx_full);
      sq_y <= $unsigned(sqy_full);
    end

    if (cmd.root_load) begin
      rad  <= sq_x + sq_y;
      rrem <= '0;
      root <= '0;
    end else if (cmd.root_step) begin
      rad <= {rad[sarec_pkg::RAD_W-3:0], 2'b00};
      if (rrem_sh >= rtrial) begin
        rrem <= rrem_sh - rtrial;
        root <= {root[sarec_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rrem <= rrem_sh;
        root <= {root[sarec_pkg::ROOT_W-2:0], 1'b0};
      end
    end

    if (cmd.check) base <= sarec_pkg::BASE_W'(distance_sum) * sarec_pkg::DEG_HALF_TURN;

    // angle sum times pi in two partial products
    if (cmd.den) begin
      p_lo <= angle_sum[sarec_pkg::MUL_SPLIT-1:0] * sarec_pkg::PI_FIXED;
      p_hi <= angle_sum[sarec_pkg::SUM_W-1:sarec_pkg::MUL_SPLIT] * sarec_pkg::PI_FIXED;
    end

    if (cmd.div_load) begin
      den    <= {p_hi, {sarec_pkg::MUL_SPLIT{1'b0}}}
              + {{(sarec_pkg::DEN_W-sarec_pkg::PLO_W){1'b0}}, p_lo};
      drem   <= {{(sarec_pkg::REM_W-HI_W){1'b0}}, num_full[NUM_W-1:sarec_pkg::QUO_W]};
      num_lo <= num_full[sarec_pkg::QUO_W-1:0];
      quo    <= '0;
    end else if (cmd.div_step) begin
      num_lo <= {num_lo[sarec_pkg::QUO_W-2:0], 1'b0};
      if (drem_sh >= den_ext) begin
        drem <= drem_sh - den_ext;
        quo  <= {quo[sarec_pkg::QUO_W-2:0], 1'b1};
      end else begin
        drem <= drem_sh;
        quo  <= {quo[sarec_pkg::QUO_W-2:0], 1'b0};
      end
    end

    // quotient of 2^40 or more saturates the radius
    if (cmd.div_check) sat <= (drem >= den_ext);

    if (cmd.emit) begin
      out_dist <= distance_sum;
      out_zero <= (angle_sum == '0);
      out_rad  <= ((angle_sum == '0) || sat) ? sarec_pkg::SUM_MAX : quo;
    end
  end

  assign m_tdata = {out_rad, out_dist};
  assign m_tuser = out_zero;

  assign status.seg_en     = seg_en;
  assign status.last       = last;
  assign status.angle_zero = (angle_sum == '0);
  assign status.div_over   = (drem >= den_ext);
  assign status.out_free   = !m_tvalid || m_tready;

endmodule

`default_nettype wire

FILE: rtl/core/section_arc_radius_estimator_core.sv
// Section arc radius estimator: segment lengths and heading sums of one
// section of a recorded path, with distance and radius given on the last
// point. A point is accepted only while the block is idle. A point whose
// segment counts (it and the previous point both in target_section) goes
// through accept, squares, load, 28 steps of the bit-serial square root
// and the accumulate. Any other point goes through accept and squares
// only. A point marked last then adds scale and zero check, the two
// partial products of the denominator, divider load, overflow check, 40
// steps of the restoring divider and the output write; with a zero angle
// sum it adds only the check and the output write. A finished result waits
// in an output register while the next points are accepted; a second
// result stalls until the first one has been taken.
`default_nettype none

module section_arc_radius_estimator_core #(
  parameter int FRAC_BITS = sarec_pkg::FRAC_BITS_DEF
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            cfg_wen,
  input  wire  [sarec_pkg::SEC_W-1:0]    cfg_wdata,   // target_section
  input  wire                            s_tvalid,
  output logic                           s_tready,
  input  wire  [sarec_pkg::TDATA_W-1:0]  s_tdata,     // point_x, point_y, point_angle, zero pad
  input  wire  [sarec_pkg::SEC_W-1:0]    s_tuser,     // point_section
  input  wire                            s_tlast,     // last_point
  output logic                           m_tvalid,
  input  wire                            m_tready,
  output logic [sarec_pkg::TDATA_W-1:0]  m_tdata,     // section_distance, section_radius
  output logic [0:0]                     m_tuser      // zero_angle
);

  sarec_pkg::cmd_t    cmd;
  sarec_pkg::status_t status;

  sarec_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  sarec_dpath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

`default_nettype wire
